>>> src/qai_pkg.sv
// Shared types, constants and the update term table of the attitude integrator.
// No dependencies; compiled first.
package qai_pkg;

  localparam int unsigned NormIterDefault = 4;
  localparam int unsigned CompW = 36;

  localparam logic [31:0]        SeedConst  = 32'd2505397589;
  localparam logic [33:0]        ThreeQ30   = 34'h0_C000_0000;
  localparam logic [33:0]        RecipThree = 34'h0_AAAA_AAAB;
  localparam logic signed [31:0] OneQ30     = 32'sh4000_0000;
  localparam logic signed [31:0] SatMax     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin     = 32'sh8000_0000;
  localparam logic [3:0]         NumTerms   = 4'd12;
  localparam logic [3:0]         NumComps   = 4'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_SCALE, ST_SQ, ST_NORM, ST_SEED, ST_NEWT, ST_OUT, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    MS_NONE, MS_UPD, MS_SQ, MS_RECIP, MS_YY, MS_XY2, MS_YH, MS_AY
  } mul_sel_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_UPD, WB_SQ, WB_SEED, WB_H, WB_Y, WB_OUT
  } wb_e;

  typedef struct packed {
    logic [1:0] comp;
    logic [1:0] qi;
    logic [1:0] di;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic     load;
    logic     scale;
    logic     norm;
    logic     ident;
    logic     out_load;
    mul_sel_e mul_sel;
    logic [3:0] mul_idx;
    wb_e      wb;
    logic [3:0] wb_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic s_norm;
  } dp_sts_t;

  function automatic term_t term_fn(input logic [3:0] idx);
    term_t t;
    unique case (idx)
      4'd0:    t = {2'd0, 2'd1, 2'd0, 1'b1};
      4'd1:    t = {2'd0, 2'd2, 2'd1, 1'b1};
      4'd2:    t = {2'd0, 2'd3, 2'd2, 1'b1};
      4'd3:    t = {2'd1, 2'd0, 2'd0, 1'b0};
      4'd4:    t = {2'd1, 2'd2, 2'd2, 1'b0};
      4'd5:    t = {2'd1, 2'd3, 2'd1, 1'b1};
      4'd6:    t = {2'd2, 2'd0, 2'd1, 1'b0};
      4'd7:    t = {2'd2, 2'd1, 2'd2, 1'b1};
      4'd8:    t = {2'd2, 2'd3, 2'd0, 1'b0};
      4'd9:    t = {2'd3, 2'd0, 2'd2, 1'b0};
      4'd10:   t = {2'd3, 2'd1, 2'd1, 1'b0};
      4'd11:   t = {2'd3, 2'd2, 2'd0, 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> src/qai_in_if.sv
// Input channel: one gyro delta-angle beat.
// Standalone interface.
interface qai_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic signed [31:0] delta_z;
  modport source (output valid, delta_x, delta_y, delta_z, input ready);
  modport sink   (input valid, delta_x, delta_y, delta_z, output ready);
endinterface

>>> src/qai_out_if.sv
// Output channel: one normalised attitude quaternion beat.
// Standalone interface.
interface qai_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] att_w;
  logic signed [31:0] att_x;
  logic signed [31:0] att_y;
  logic signed [31:0] att_z;
  modport source (output valid, att_w, att_x, att_y, att_z, input ready);
  modport sink   (input valid, att_w, att_x, att_y, att_z, output ready);
endinterface

>>> src/qai_dpath.sv
// Datapath: attitude state, shared 34x34 multiplier, accumulators, normaliser.
// Depends on qai_pkg.
module qai_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] delta_x_i,
  input  logic signed [31:0] delta_y_i,
  input  logic signed [31:0] delta_z_i,
  input  qai_pkg::dp_cmd_t   cmd_i,
  output qai_pkg::dp_sts_t   sts_o,
  output logic signed [31:0] att_w_o,
  output logic signed [31:0] att_x_o,
  output logic signed [31:0] att_y_o,
  output logic signed [31:0] att_z_o
);
  import qai_pkg::*;

  logic signed [31:0]      att_q [4];
  logic signed [31:0]      d_q [3];
  logic signed [CompW-1:0] c_q [4];
  logic [30:0]             a_q [4];
  logic [3:0]              neg_q;
  logic [63:0]             s_q;
  logic [5:0]              e_q;
  logic [31:0]             y_q, h_q;
  logic [67:0]             prod_q, prod_d;
  logic                    pneg_q, pneg_d;
  logic [31:0]             out_q [4];

  logic [33:0]      op_a, op_b;
  term_t            mt, wt;
  logic signed [31:0] qv, dv;
  logic [CompW-1:0] cm [4];
  logic [CompW-1:0] orv;
  logic [2:0]       k;
  logic [63:0]      rsum;
  logic [34:0]      tmag;
  logic [33:0]      tval, yn;
  logic [5:0]       sh;
  logic [63:0]      osum, rv;
  logic [31:0]      sat_v;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    mt   = term_fn(cmd_i.mul_idx);
    qv   = att_q[mt.qi];
    dv   = d_q[(mt.di == 2'd3) ? 2'd0 : mt.di];
    op_a = '0;
    op_b = '0;
    pneg_d = 1'b0;
    unique case (cmd_i.mul_sel)
      MS_UPD: begin
        op_a   = {2'b0, mag32(qv)};
        op_b   = {2'b0, mag32(dv)};
        pneg_d = qv[31] ^ dv[31] ^ mt.neg;
      end
      MS_SQ: begin
        op_a = {3'b0, a_q[cmd_i.mul_idx[1:0]]};
        op_b = {3'b0, a_q[cmd_i.mul_idx[1:0]]};
      end
      MS_RECIP: begin
        op_a = {2'b0, s_q[63:34], 2'b0};
        op_b = RecipThree;
      end
      MS_YY: begin
        op_a = {2'b0, y_q};
        op_b = {2'b0, y_q};
      end
      MS_XY2: begin
        op_a = {4'b0, s_q[63:34]};
        op_b = prod_q[63:30];
      end
      MS_YH: begin
        op_a = {2'b0, y_q};
        op_b = {2'b0, h_q};
      end
      MS_AY: begin
        op_a = {3'b0, a_q[cmd_i.mul_idx[1:0]]};
        op_b = {2'b0, y_q};
      end
      default: ;
    endcase
    prod_d = op_a * op_b;
  end

  always_comb begin
    wt   = term_fn(cmd_i.wb_idx);
    rsum = prod_q[63:0] + 64'h1000_0000;
    tmag = rsum[63:29];
    tval = prod_q[63:30];
    yn   = prod_q[64:31];
    for (int i = 0; i < 4; i++) begin
      cm[i] = c_q[i][CompW-1] ? CompW'(-c_q[i]) : CompW'(c_q[i]);
    end
    orv = cm[0] | cm[1] | cm[2] | cm[3];
    priority if (orv[35]) k = 3'd5;
    else if (orv[34])     k = 3'd4;
    else if (orv[33])     k = 3'd3;
    else if (orv[32])     k = 3'd2;
    else if (orv[31])     k = 3'd1;
    else                  k = 3'd0;
    sh   = 6'd32 - {1'b0, e_q[5:1]};
    osum = prod_q[63:0] + (64'd1 << (sh - 6'd1));
    rv   = osum >> sh;
    if (neg_q[cmd_i.wb_idx[1:0]]) begin
      sat_v = (rv >= 64'h8000_0000) ? SatMin : 32'(-rv[31:0]);
    end else begin
      sat_v = (rv > 64'h7FFF_FFFF) ? SatMax : rv[31:0];
    end
  end

  assign sts_o.s_zero = (s_q == '0);
  assign sts_o.s_norm = s_q[63] | s_q[62];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q[0] <= OneQ30;
      att_q[1] <= '0;
      att_q[2] <= '0;
      att_q[3] <= '0;
    end else if (cmd_i.ident) begin
      att_q[0] <= OneQ30;
      att_q[1] <= '0;
      att_q[2] <= '0;
      att_q[3] <= '0;
    end else if (cmd_i.wb == WB_OUT) begin
      att_q[cmd_i.wb_idx[1:0]] <= sat_v;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pneg_q <= pneg_d;
    if (cmd_i.load) begin
      d_q[0] <= delta_x_i;
      d_q[1] <= delta_y_i;
      d_q[2] <= delta_z_i;
      for (int i = 0; i < 4; i++) c_q[i] <= CompW'(att_q[i]);
    end
    if (cmd_i.wb == WB_UPD) begin
      c_q[wt.comp] <= pneg_q ? c_q[wt.comp] - $signed({1'b0, tmag})
                             : c_q[wt.comp] + $signed({1'b0, tmag});
    end
    if (cmd_i.scale) begin
      for (int i = 0; i < 4; i++) begin
        a_q[i]   <= 31'(cm[i] >> k);
        neg_q[i] <= c_q[i][CompW-1];
      end
      s_q <= '0;
      e_q <= '0;
    end
    if (cmd_i.wb == WB_SQ) s_q <= s_q + prod_q[63:0];
    if (cmd_i.norm && !sts_o.s_zero && !sts_o.s_norm) begin
      if (s_q[63:56] == '0) begin
        s_q <= s_q << 8;
        e_q <= e_q + 6'd8;
      end else begin
        s_q <= s_q << 2;
        e_q <= e_q + 6'd2;
      end
    end
    if (cmd_i.wb == WB_SEED) y_q <= SeedConst - prod_q[64:33];
    if (cmd_i.wb == WB_H) h_q <= (tval >= ThreeQ30) ? '0 : 32'(ThreeQ30 - tval);
    if (cmd_i.wb == WB_Y) y_q <= (yn > ThreeQ30) ? ThreeQ30[31:0] : yn[31:0];
    if (cmd_i.out_load) begin
      for (int i = 0; i < 4; i++) out_q[i] <= att_q[i];
    end
  end

  assign att_w_o = out_q[0];
  assign att_x_o = out_q[1];
  assign att_y_o = out_q[2];
  assign att_z_o = out_q[3];

endmodule

>>> src/qai_ctrl.sv
// Controller: sequences update, scaling, normalisation and Newton steps.
// Depends on qai_pkg.
module qai_ctrl #(
  parameter int unsigned NORM_ITERATIONS = qai_pkg::NormIterDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  qai_pkg::dp_sts_t sts_i,
  output qai_pkg::dp_cmd_t cmd_o
);
  import qai_pkg::*;

  localparam int unsigned IterW = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(NORM_ITERATIONS - 1);

  state_e           state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q + 4'd1;
    iter_d  = iter_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (step_q == NumTerms) begin
          state_d = ST_SCALE;
          step_d  = '0;
        end
      end
      ST_SCALE: begin
        state_d = ST_SQ;
        step_d  = '0;
      end
      ST_SQ: begin
        if (step_q == NumComps) begin
          state_d = ST_NORM;
          step_d  = '0;
        end
      end
      ST_NORM: begin
        step_d = '0;
        if (sts_i.s_zero) state_d = ST_FIN;
        else if (sts_i.s_norm) state_d = ST_SEED;
      end
      ST_SEED: begin
        if (step_q == 4'd1) begin
          state_d = ST_NEWT;
          step_d  = '0;
          iter_d  = '0;
        end
      end
      ST_NEWT: begin
        if (step_q == 4'd4) begin
          step_d = '0;
          if (iter_q == IterLast) state_d = ST_OUT;
          else iter_d = iter_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (step_q == NumComps) begin
          state_d = ST_FIN;
          step_d  = '0;
        end
      end
      ST_FIN: begin
        step_d = '0;
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_UPD: begin
        if (step_q < NumTerms) begin
          cmd_o.mul_sel = MS_UPD;
          cmd_o.mul_idx = step_q;
        end
        if (step_q != '0) begin
          cmd_o.wb     = WB_UPD;
          cmd_o.wb_idx = step_q - 4'd1;
        end
      end
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_SQ: begin
        if (step_q < NumComps) begin
          cmd_o.mul_sel = MS_SQ;
          cmd_o.mul_idx = step_q;
        end
        if (step_q != '0) begin
          cmd_o.wb     = WB_SQ;
          cmd_o.wb_idx = step_q - 4'd1;
        end
      end
      ST_NORM: begin
        cmd_o.norm  = 1'b1;
        cmd_o.ident = sts_i.s_zero;
      end
      ST_SEED: begin
        if (step_q == '0) cmd_o.mul_sel = MS_RECIP;
        else cmd_o.wb = WB_SEED;
      end
      ST_NEWT: begin
        unique case (step_q)
          4'd0:    cmd_o.mul_sel = MS_YY;
          4'd1:    cmd_o.mul_sel = MS_XY2;
          4'd2:    cmd_o.wb      = WB_H;
          4'd3:    cmd_o.mul_sel = MS_YH;
          default: cmd_o.wb      = WB_Y;
        endcase
      end
      ST_OUT: begin
        if (step_q < NumComps) begin
          cmd_o.mul_sel = MS_AY;
          cmd_o.mul_idx = step_q;
        end
        if (step_q != '0) begin
          cmd_o.wb     = WB_OUT;
          cmd_o.wb_idx = step_q - 4'd1;
        end
      end
      ST_FIN: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/quaternion_attitude_integrator_unit.sv
// Quaternion attitude integrator: first-order update, then Newton renormalisation.
// All products go through the single shared 34x34 multiplier, so a new item is not taken
// until the last one is through; a zero-length result skips the Newton steps and gives
// the identity attitude.
// One item at a time; a finished beat waits in the output register while
// the next item is taken. Reset sets the attitude to identity (w = 1.0).
module quaternion_attitude_integrator_unit #(
  parameter int unsigned NORM_ITERATIONS = qai_pkg::NormIterDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  qai_in_if.sink    in_i,
  qai_out_if.source out_o
);
  import qai_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  qai_ctrl #(
    .NORM_ITERATIONS(NORM_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qai_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .delta_x_i(in_i.delta_x),
    .delta_y_i(in_i.delta_y),
    .delta_z_i(in_i.delta_z),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .att_w_o  (out_o.att_w),
    .att_x_o  (out_o.att_x),
    .att_y_o  (out_o.att_y),
    .att_z_o  (out_o.att_z)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the quaternion attitude integrator: gyro delta beats are
// driven in, each normalised attitude beat is checked against a bit-exact predictor.
// Depends on qai_pkg, qai_in_if, qai_out_if and quaternion_attitude_integrator_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qai_pkg::*;

  localparam int unsigned NormIters = NormIterDefault;
  localparam int unsigned NumItems  = 1950;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  class attitude_board;
    logic signed [31:0] att [4];
    quat_t pending [$];
    int unsigned fails;
    int unsigned checked;

    function new();
      att[0] = OneQ30; att[1] = 0; att[2] = 0; att[3] = 0;
      fails = 0;
      checked = 0;
    endfunction

    function longint half_term(longint p);
      longint unsigned m;
      m = p < 0 ? -p : p;
      m = (m + (64'd1 << 28)) >> 29;
      return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function void note_delta(logic signed [31:0] dx, logic signed [31:0] dy,
                             logic signed [31:0] dz);
      longint c [4];
      longint w, x, y, z, ddx, ddy, ddz;
      longint unsigned a [4], s, x30, yv, y2, t, h, r;
      bit neg [4];
      int unsigned k, e, sh;
      bit big;
      quat_t q;
      w = att[0]; x = att[1]; y = att[2]; z = att[3];
      ddx = dx; ddy = dy; ddz = dz;
      c[0] = w - half_term(x*ddx) - half_term(y*ddy) - half_term(z*ddz);
      c[1] = x + half_term(w*ddx) + half_term(y*ddz) - half_term(z*ddy);
      c[2] = y + half_term(w*ddy) - half_term(x*ddz) + half_term(z*ddx);
      c[3] = z + half_term(w*ddz) + half_term(x*ddy) - half_term(y*ddx);
      for (int i = 0; i < 4; i++) begin
        neg[i] = c[i] < 0;
        a[i] = c[i] < 0 ? -c[i] : c[i];
      end
      k = 0;
      do begin
        big = 0;
        for (int i = 0; i < 4; i++) if ((a[i] >> k) >= 64'h8000_0000) big = 1;
        if (big) k++;
      end while (big && k < 63);
      s = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = a[i] >> k;
        s += a[i] * a[i];
      end
      if (s == 0) begin
        att[0] = OneQ30; att[1] = 0; att[2] = 0; att[3] = 0;
      end else begin
        e = 0;
        while (s < (64'd1 << 62)) begin
          s = s << 2;
          e += 2;
        end
        x30 = s >> 34;
        yv = 64'd2505397589 - (4 * x30) / 3;
        for (int it = 0; it < NormIters; it++) begin
          y2 = (yv * yv) >> 30;
          t = (x30 * y2) >> 30;
          h = t >= (64'd3 << 30) ? 0 : (64'd3 << 30) - t;
          yv = (yv * h) >> 31;
          if (yv > (64'd3 << 30)) yv = 64'd3 << 30;
        end
        sh = 32 - e / 2;
        for (int i = 0; i < 4; i++) begin
          r = (a[i] * yv + (64'd1 << (sh - 1))) >> sh;
          if (neg[i]) att[i] = r >= 64'h8000_0000 ? SatMin : -longint'(r);
          else att[i] = r > 64'h7FFF_FFFF ? SatMax : r[31:0];
        end
      end
      q.w = att[0]; q.x = att[1]; q.y = att[2]; q.z = att[3];
      pending.push_back(q);
    endfunction

    function void check_attitude(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $display("%0t: unexpected attitude beat %h", $time, got);
        fails++;
        return;
      end
      exp_q = pending.pop_front();
      checked++;
      if (got.w !== exp_q.w) begin
        $display("%0t: att_w expected %h actual %h", $time, exp_q.w, got.w); fails++;
      end
      if (got.x !== exp_q.x) begin
        $display("%0t: att_x expected %h actual %h", $time, exp_q.x, got.x); fails++;
      end
      if (got.y !== exp_q.y) begin
        $display("%0t: att_y expected %h actual %h", $time, exp_q.y, got.y); fails++;
      end
      if (got.z !== exp_q.z) begin
        $display("%0t: att_z expected %h actual %h", $time, exp_q.z, got.z); fails++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #6 clk_i = ~clk_i;

  qai_in_if  in_ch ();
  qai_out_if out_ch ();

  quaternion_attitude_integrator_unit #(.NORM_ITERATIONS(NormIters)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  attitude_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned deltas_sent = 0;
  longint unsigned cycle_count = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.delta_x = 0;
    in_ch.delta_y = 0;
    in_ch.delta_z = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_attitude({out_ch.att_w, out_ch.att_x, out_ch.att_y, out_ch.att_z});
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_delta(logic signed [31:0] dx, logic signed [31:0] dy,
                            logic signed [31:0] dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.delta_x <= dx;
    in_ch.delta_y <= dy;
    in_ch.delta_z <= dz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_delta(dx, dy, dz);
    deltas_sent++;
  endtask

  function automatic logic signed [31:0] rand_delta();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 0;
      default: return $signed($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_delta(rand_delta(), rand_delta(), rand_delta());
  endtask

  initial begin
    logic signed [31:0] corner [6];
    int unsigned drain;
    corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1, 32'sh1000_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes on each axis, all axes together
    for (int i = 0; i < 6; i++) send_delta(corner[i], 0, 0);
    for (int i = 0; i < 6; i++) send_delta(0, corner[i], 0);
    for (int i = 0; i < 6; i++) send_delta(0, 0, corner[i]);
    send_delta(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_delta(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_delta(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    random_phase(480, 0, 0);
    // hold off the receiver so the block backs up
    hold_off_cycles = 400;
    random_phase(10, 0, 0);
    random_phase(480, 88, 0);
    random_phase(480, 0, 88);
    random_phase(480, 32, 32);
    in_ch.valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 100) begin
      @(posedge clk_i);
      drain++;
    end
    $display("Sent %0d gyro deltas (corners, random, idle/stall mixes, long hold-off);",
             deltas_sent);
    $display("checked %0d attitude beats with %0d field mismatches.",
             board.checked, board.fails);
    if (board.fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
